@@ rtl/plb_pkg.sv @@
// plb_pkg: shared types and codes for the positional list buffer
// request and result beat structs, request and status codes
// no dependencies
package plb_pkg;

  localparam int DATA_W      = 32;
  localparam int POS_W       = 7;
  localparam int CNT_FIELD_W = 7;
  localparam int REQ_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int GROUP_SIZE  = 8;

  localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_TAIL = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_POS  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REM_HEAD = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REM_TAIL = 3'd4;
  localparam logic [REQ_W-1:0] REQ_REM_POS  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ERR  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]      removed_value;
    logic [STATUS_W-1:0]    status;
    logic [CNT_FIELD_W-1:0] entry_count;
  } rsp_t;

  // shift command broadcast to every cell, only set for requests that succeed
  typedef struct packed {
    logic ins;
    logic rem;
  } op_t;

endpackage

@@ rtl/plb_cell.sv @@
// plb_cell: one slot of the list, a register that loads from its left or
// right neighbor or from the new value; uses plb_pkg
module plb_cell #(
  parameter int EW    = 32,
  parameter int CW    = 7,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  plb_pkg::op_t     op,
  input  logic [CW-1:0]    at,
  input  logic [EW-1:0]    new_value,
  input  logic [EW-1:0]    left,
  input  logic [EW-1:0]    right,
  output logic [EW-1:0]    data,
  output logic [EW-1:0]    tap
);
  import plb_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

  logic at_me;
  logic above;

  assign at_me = (at == MY_IDX);
  assign above = (MY_IDX > at);

  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (above) begin
        data <= left;
      end else if (at_me) begin
        data <= new_value;
      end
    end else if (op.rem) begin
      if (above || at_me) begin
        data <= right;
      end
    end
  end

  // removed entry, zero unless this cell is the one taken out
  assign tap = (op.rem && at_me) ? data : '0;

endmodule

@@ rtl/plb_ctrl.sv @@
// plb_ctrl: request decode, bounds checks, entry count and first result stage
// uses plb_pkg
module plb_ctrl #(
  parameter int CAPACITY = 64,
  parameter int CW       = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  plb_pkg::req_t                 req,
  output plb_pkg::op_t                  op,
  output logic [CW-1:0]                 at,
  output logic                          v1,
  output logic [plb_pkg::STATUS_W-1:0]  st1,
  output logic [CW-1:0]                 cnt1
);
  import plb_pkg::*;

  localparam int CMP_W = CW + POS_W;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [CW-1:0]       tail_idx;
  logic [CMP_W-1:0]    at_w;
  logic [CMP_W-1:0]    cnt_w;
  logic [CMP_W-1:0]    pos_w;
  logic [CMP_W-1:0]    tail_w;
  logic                is_ins;
  logic                is_rem;
  logic [STATUS_W-1:0] status;

  assign tail_idx = count - 1'b1;
  assign cnt_w    = {{POS_W{1'b0}}, count};
  assign tail_w   = {{POS_W{1'b0}}, tail_idx};
  assign pos_w    = {{CW{1'b0}}, req.position};

  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    at_w   = '0;
    unique case (req.req_type)
      REQ_INS_HEAD: begin
        is_ins = 1'b1;
      end
      REQ_INS_TAIL: begin
        is_ins = 1'b1;
        at_w   = cnt_w;
      end
      REQ_INS_POS: begin
        is_ins = 1'b1;
        at_w   = pos_w;
      end
      REQ_REM_HEAD: begin
        is_rem = 1'b1;
      end
      REQ_REM_TAIL: begin
        is_rem = 1'b1;
        at_w   = tail_w;
      end
      REQ_REM_POS: begin
        is_rem = 1'b1;
        at_w   = pos_w;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status = ST_ERR;
    if (is_ins) begin
      if (at_w > cnt_w) begin
        status = ST_ERR;
      end else if (count >= CAP_CNT) begin
        status = ST_FULL;
      end else begin
        status = ST_OK;
      end
    end else if (is_rem) begin
      // an empty list fails here too, as every index is at or above zero
      if (count == '0 || at_w >= cnt_w) begin
        status = ST_ERR;
      end else begin
        status = ST_OK;
      end
    end
  end

  assign op.ins = accept && is_ins && (status == ST_OK);
  assign op.rem = accept && is_rem && (status == ST_OK);
  assign at     = at_w[CW-1:0];

  always_comb begin
    count_next = count;
    if (op.ins) begin
      count_next = count + 1'b1;
    end else if (op.rem) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      v1    <= 1'b0;
    end else begin
      count <= count_next;
      v1    <= accept;
    end
  end

  always_ff @(posedge clk) begin
    st1  <= status;
    cnt1 <= count_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("entry count above capacity");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    op.rem |=> count == $past(count) - 1'b1)
    else $error("successful remove did not shrink the list");

  a_full_only_at_cap: assert property (@(posedge clk) disable iff (rst)
    (v1 && st1 == ST_FULL) |-> count == CAP_CNT)
    else $error("full status while list has room");

endmodule

@@ rtl/plb_collect.sv @@
// plb_collect: two-level registered or-tree that gathers the removed entry
// from the cell taps; uses plb_pkg
module plb_collect #(
  parameter int CAPACITY = 64,
  parameter int EW       = 32
) (
  input  logic          clk,
  input  logic [EW-1:0] tap [CAPACITY],
  output logic [EW-1:0] value
);
  import plb_pkg::*;

  localparam int NGRP = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [EW-1:0] grp [NGRP];

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    localparam int LO = g * GROUP_SIZE;
    localparam int HI = ((g + 1) * GROUP_SIZE < CAPACITY) ? (g + 1) * GROUP_SIZE : CAPACITY;

    logic [EW-1:0] part;

    always_comb begin
      part = '0;
      for (int k = LO; k < HI; k++) begin
        part = part | tap[k];
      end
    end

    always_ff @(posedge clk) begin
      grp[g] <= part;
    end
  end

  always_comb begin
    value = '0;
    for (int g = 0; g < NGRP; g++) begin
      value = value | grp[g];
    end
  end

endmodule

@@ rtl/positional_list_buffer.sv @@
// positional_list_buffer: top level, a row of list cells with decode and
// result collection; uses plb_pkg, plb_ctrl, plb_cell, plb_collect
//
// An ordered list of up to CAPACITY entries held in a row of cells, one entry
// per cell. A request beat is taken on every clock edge where start is high;
// busy never rises, so one request per cycle is sustained. Every request
// gives exactly one result beat, marked by done for a single cycle. The
// request is registered into v1, st1 and cnt1 while the removed entry is
// gathered through a two-level registered or-tree; the result beat register
// then drives done and rsp. The result beat cannot be held off, so the
// receiver must take it when done is high. Inserts move every cell above the
// index one place up, removes pull every cell from the index upward one place
// down, all in the request cycle, so the next request sees the updated list.
// status is ok, error (bad index, empty list or unknown code) or full; a
// failed request leaves the list as it was and returns zero as
// removed_value. entry_count is the count after the request. Cells need no
// clearing after reset: only entries below the count are ever read.
module positional_list_buffer #(
  parameter int CAPACITY    = 64,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  plb_pkg::req_t  req,
  output logic           done,
  output plb_pkg::rsp_t  rsp
);
  import plb_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = ENTRY_WIDTH;

  logic                 accept;
  op_t                  op;
  logic [CW-1:0]        at;
  logic                 v1;
  logic [STATUS_W-1:0]  st1;
  logic [CW-1:0]        cnt1;
  logic [EW-1:0]        new_value;
  logic [EW-1:0]        cell_q   [CAPACITY];
  logic [EW-1:0]        cell_tap [CAPACITY];
  logic [EW-1:0]        picked;

  // widened forms for explicit extend or truncate at the field boundaries
  logic [EW+DATA_W-1:0]      value_wide;
  logic [EW+DATA_W-1:0]      picked_wide;
  logic [CW+CNT_FIELD_W-1:0] cnt_wide;

  // never stalls: every request finishes its list update at the edge it is taken
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // only the low ENTRY_WIDTH bits of the value are kept
  assign value_wide = {{EW{1'b0}}, req.entry_value};
  assign new_value  = value_wide[EW-1:0];

  plb_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .op     (op),
    .at     (at),
    .v1     (v1),
    .st1    (st1),
    .cnt1   (cnt1)
  );

  // the row of cells, each wired to its two neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [EW-1:0] left;
    logic [EW-1:0] right;

    if (i == 0) begin : g_first
      assign left = new_value;
    end else begin : g_mid_l
      assign left = cell_q[i-1];
    end

    // last cell reloads itself on a remove, the slot falls out of the count
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_q[i];
    end else begin : g_mid_r
      assign right = cell_q[i+1];
    end

    plb_cell #(
      .EW    (EW),
      .CW    (CW),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .at        (at),
      .new_value (new_value),
      .left      (left),
      .right     (right),
      .data      (cell_q[i]),
      .tap       (cell_tap[i])
    );
  end

  // removed entry tapped in the same cycle as the shift, before it lands
  plb_collect #(
    .CAPACITY (CAPACITY),
    .EW       (EW)
  ) u_collect (
    .clk   (clk),
    .tap   (cell_tap),
    .value (picked)
  );

  assign picked_wide = {{DATA_W{1'b0}}, picked};
  assign cnt_wide    = {{CNT_FIELD_W{1'b0}}, cnt1};

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v1;
    end
  end

  always_ff @(posedge clk) begin
    rsp.removed_value <= picked_wide[DATA_W-1:0];
    rsp.status        <= st1;
    rsp.entry_count   <= cnt_wide[CNT_FIELD_W-1:0];
  end

  a_done_follows_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result beat without a request two cycles earlier");

  a_fail_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |-> rsp.removed_value == '0)
    else $error("failed request returned a nonzero entry");

  a_single_shift: assert property (@(posedge clk) disable iff (rst)
    !(op.ins && op.rem))
    else $error("insert and remove shift in the same cycle");

endmodule
